// File: sv/http_header_field_tokenizer_defines.svh
// Assertion macros used by the tokenizer parser module (hhft_fsm).
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef HTTP_HEADER_FIELD_TOKENIZER_DEFINES_SVH
`define HTTP_HEADER_FIELD_TOKENIZER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HHFT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define HHFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/hhft_pkg.sv
package hhft_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OFFSET_W = 9;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ERR_W    = 3;

    localparam logic [OFFSET_W-1:0] MAX_OFFSET_RESET = 9'd255;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEP   = 3'd0,
        KIND_KEY   = 3'd1,
        KIND_VALUE = 3'd2,
        KIND_FEND  = 3'd3,
        KIND_HEND  = 3'd4,
        KIND_ERR   = 3'd5,
        KIND_IGN   = 3'd6
    } byte_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_KEY_CRLF  = 3'd1,
        ERR_NO_SPACE  = 3'd2,
        ERR_VALUE_LEN = 3'd3,
        ERR_CR_NO_LF  = 3'd4
    } err_code_t;

    // Classification of one byte, handed from the parser to the output stage
    typedef struct packed {
        byte_kind_t kind;
        err_code_t  err;
    } hhft_result_t;

endpackage

// File: sv/http_header_field_tokenizer.sv
// A request is registered in the input stage and then in the result stage,
// which drives the m_ outputs.
// Throughput: one byte per cycle unless the result side stalls.
// Stalls on the result side back-pressure the input only when both stages hold data.
// Reset (rst_n low, asynchronous) empties both stages, returns the parser to its
// start phase with offset zero and sets max_value_offset to 255.
module http_header_field_tokenizer
    import hhft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic [0:0]          s_tuser,   // [0] new_request
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] byte_out, [10:8] error_code, rest zero
    output logic [2:0]          m_tuser,   // [2:0] byte_kind
    input  logic                cfg_wen,
    input  logic [OFFSET_W-1:0] cfg_wdata
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_newreq_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    hhft_result_t        out_result_reg;
    logic [OFFSET_W-1:0] max_offset_reg;
    logic                advance;
    hhft_result_t        result;

    // Move a request into the result register when it is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hhft_fsm u_fsm (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .data_byte        (in_byte_reg),
        .new_request      (in_newreq_reg),
        .max_value_offset (max_offset_reg),
        .result           (result)
    );

    // Stage occupancy and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_offset_reg <= MAX_OFFSET_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wen)
            begin
                max_offset_reg <= cfg_wdata;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg   <= s_tdata;
            in_newreq_reg <= s_tuser[0];
        end
        if (advance)
        begin
            out_byte_reg   <= in_byte_reg;
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_result_reg.err, out_byte_reg};
    assign m_tuser  = out_result_reg.kind;

endmodule

// File: sv/hhft_fsm.sv
module hhft_fsm
    import hhft_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                new_request,
    input  logic [OFFSET_W-1:0] max_value_offset,
    output hhft_result_t        result
);

`include "http_header_field_tokenizer_defines.svh"

    typedef enum logic [3:0] {
        PH_START     = 4'd0,
        PH_KEY       = 4'd1,
        PH_COLON     = 4'd2,
        PH_SPACE     = 4'd3,
        PH_VALUE     = 4'd4,
        PH_CR        = 4'd5,
        PH_LF        = 4'd6,
        PH_END_CR    = 4'd7,
        PH_DONE      = 4'd8,
        PH_ERR_KEY   = 4'd9,
        PH_ERR_SPACE = 4'd10,
        PH_ERR_LEN   = 4'd11,
        PH_ERR_CRLF  = 4'd12
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    phase_t              phase_cur;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic [OFFSET_W-1:0] offset_cur;
    logic [OFFSET_W:0]   offset_inc;
    logic                is_cr;
    logic                is_lf;
    logic                hold_step;
    logic                err_phase;

    assign is_cr = (data_byte == CH_CR);
    assign is_lf = (data_byte == CH_LF);

    // Restart the parser ahead of this byte on a new request
    assign phase_cur  = new_request ? PH_START : phase_reg;
    assign offset_cur = new_request ? '0 : offset_reg;
    assign offset_inc = {1'b0, offset_cur} + {{OFFSET_W{1'b0}}, 1'b1};

    // Classify the byte and work out the following phase
    always_comb
    begin
        phase_next  = phase_cur;
        offset_next = offset_cur;
        result.kind = KIND_SEP;
        result.err  = ERR_NONE;
        case (phase_cur)
            PH_START:
            begin
                if (!is_cr && !is_lf)
                begin
                    phase_next  = PH_KEY;
                    result.kind = KIND_KEY;
                end
            end
            PH_KEY:
            begin
                if (data_byte == CH_COLON)
                begin
                    phase_next = PH_COLON;
                end
                else if (is_cr || is_lf)
                begin
                    phase_next  = PH_ERR_KEY;
                    result.kind = KIND_ERR;
                    result.err  = ERR_KEY_CRLF;
                end
                else
                begin
                    result.kind = KIND_KEY;
                end
            end
            PH_COLON:
            begin
                if (data_byte == CH_SPACE)
                begin
                    phase_next = PH_SPACE;
                end
                else
                begin
                    phase_next  = PH_ERR_SPACE;
                    result.kind = KIND_ERR;
                    result.err  = ERR_NO_SPACE;
                end
            end
            PH_SPACE:
            begin
                // first value byte is taken whatever it is
                phase_next  = PH_VALUE;
                offset_next = '0;
                result.kind = KIND_VALUE;
            end
            PH_VALUE:
            begin
                if (is_cr)
                begin
                    phase_next = PH_CR;
                end
                else if (offset_inc > {1'b0, max_value_offset})
                begin
                    phase_next  = PH_ERR_LEN;
                    result.kind = KIND_ERR;
                    result.err  = ERR_VALUE_LEN;
                end
                else
                begin
                    offset_next = offset_inc[OFFSET_W-1:0];
                    result.kind = KIND_VALUE;
                end
            end
            PH_CR:
            begin
                if (is_lf)
                begin
                    phase_next  = PH_LF;
                    result.kind = KIND_FEND;
                end
                else
                begin
                    phase_next  = PH_ERR_CRLF;
                    result.kind = KIND_ERR;
                    result.err  = ERR_CR_NO_LF;
                end
            end
            PH_LF:
            begin
                if (is_cr)
                begin
                    phase_next = PH_END_CR;
                end
                else
                begin
                    phase_next  = PH_KEY;
                    result.kind = KIND_KEY;
                end
            end
            PH_END_CR:
            begin
                if (is_lf)
                begin
                    phase_next  = PH_DONE;
                    result.kind = KIND_HEND;
                end
                else
                begin
                    phase_next  = PH_ERR_CRLF;
                    result.kind = KIND_ERR;
                    result.err  = ERR_CR_NO_LF;
                end
            end
            PH_DONE:
            begin
                result.kind = KIND_IGN;
            end
            // Hold a sticky error and repeat its code
            PH_ERR_KEY:
            begin
                result.kind = KIND_ERR;
                result.err  = ERR_KEY_CRLF;
            end
            PH_ERR_SPACE:
            begin
                result.kind = KIND_ERR;
                result.err  = ERR_NO_SPACE;
            end
            PH_ERR_LEN:
            begin
                result.kind = KIND_ERR;
                result.err  = ERR_VALUE_LEN;
            end
            PH_ERR_CRLF:
            begin
                result.kind = KIND_ERR;
                result.err  = ERR_CR_NO_LF;
            end
            default:
            begin
                phase_next  = PH_START;
                offset_next = '0;
            end
        endcase
    end

    // Advance parser state once per classified byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            offset_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
        end
    end

    // Terms used by the checks below
    assign hold_step = step && !new_request;
    assign err_phase = phase_reg inside {PH_ERR_KEY, PH_ERR_SPACE, PH_ERR_LEN, PH_ERR_CRLF};

    `HHFT_ASSERT_SAME(a_err_has_code, result.kind == KIND_ERR, result.err != ERR_NONE)
    `HHFT_ASSERT_SAME(a_code_only_on_err, result.kind != KIND_ERR, result.err == ERR_NONE)
    `HHFT_ASSERT_NEXT(a_done_holds, hold_step && phase_reg == PH_DONE, phase_reg == PH_DONE)
    `HHFT_ASSERT_NEXT(a_err_sticky, hold_step && result.kind == KIND_ERR, err_phase)

endmodule
